// File: hw/rtl/button_gesture_detector_defines.svh
// ---------------------------------------------------------------------------
// Button gesture detector assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef BUTTON_GESTURE_DETECTOR_DEFINES_SVH
`define BUTTON_GESTURE_DETECTOR_DEFINES_SVH

// same-cycle implication
`define BGD_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BGD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/bgd_pkg.sv
// ---------------------------------------------------------------------------
// Button gesture detector package
// Field widths, register codes, gesture states and shared record types.
// ---------------------------------------------------------------------------
`default_nettype none

package bgd_pkg;

	localparam int LEVEL_W  = 16;
	localparam int IDX_W    = 4;
	localparam int PERIOD_W = 10;
	localparam int MS_W     = 16;
	localparam int ACTIVE_W = 5;
	localparam int HELD_W   = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int GST_W    = 4;

	localparam logic [PERIOD_W-1:0] RST_TICK_PERIOD  = PERIOD_W'(10);
	localparam logic [MS_W-1:0]     RST_CLICK_MS     = MS_W'(100);
	localparam logic [MS_W-1:0]     RST_RELEASE_MS   = MS_W'(40);
	localparam logic [MS_W-1:0]     RST_LONG_PUSH_MS = MS_W'(1000);
	localparam logic [MS_W-1:0]     RST_LONG_REL_MS  = MS_W'(80);
	localparam logic [LEVEL_W-1:0]  RST_SINGLE_MASK  = '0;
	localparam logic [ACTIVE_W-1:0] RST_ACTIVE       = ACTIVE_W'(16);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TICK_PERIOD  = 3'd0,
		CFG_CLICK_MS     = 3'd1,
		CFG_RELEASE_MS   = 3'd2,
		CFG_LONG_PUSH_MS = 3'd3,
		CFG_LONG_REL_MS  = 3'd4,
		CFG_SINGLE_MASK  = 3'd5,
		CFG_ACTIVE       = 3'd6
	} cfg_idx_t;

	typedef enum logic [GST_W-1:0] {
		GST_INIT       = 4'd0,
		GST_START      = 4'd1,
		GST_CLICK_DET  = 4'd2,
		GST_LONG_DET   = 4'd3,
		GST_SURE_LONG  = 4'd4,
		GST_LPREL_DET  = 4'd5,
		GST_SURE_LPREL = 4'd6,
		GST_CLREL_DET  = 4'd7,
		GST_DBL_DET    = 4'd8,
		GST_SURE_CLICK = 4'd9,
		GST_SURE_DBL   = 4'd10
	} gesture_state_t;

	typedef enum logic [2:0] {
		SEQ_IDLE,
		SEQ_READ,
		SEQ_MUL,
		SEQ_EXEC,
		SEQ_PUSH,
		SEQ_FLUSH
	} seq_state_t;

	typedef struct packed {
		logic [PERIOD_W-1:0] tick_period_ms;
		logic [MS_W-1:0]     click_ms;
		logic [MS_W-1:0]     release_ms;
		logic [MS_W-1:0]     long_push_ms;
		logic [MS_W-1:0]     long_release_ms;
		logic [LEVEL_W-1:0]  single_click_only_mask;
		logic [ACTIVE_W-1:0] active_buttons;
	} cfg_t;

	typedef struct packed {
		logic              click_seen;
		logic              double_click_seen;
		logic              long_push_seen;
		logic              long_release_seen;
		logic [HELD_W-1:0] held_ticks;
	} gesture_evt_t;

	typedef struct packed {
		logic [IDX_W-1:0]  button_index;
		logic              click_seen;
		logic              double_click_seen;
		logic              long_push_seen;
		logic              long_release_seen;
		logic [HELD_W-1:0] held_ticks;
		logic              last_of_tick;
	} result_t;

endpackage

`default_nettype wire

// File: hw/rtl/bgd_if.sv
// ---------------------------------------------------------------------------
// Button gesture detector channels
// Valid/ready request channels for button samples and gesture results.
// ---------------------------------------------------------------------------
`default_nettype none

interface bgd_in_if import bgd_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [LEVEL_W-1:0] button_levels;

	modport source(output valid, output button_levels, input ready);
	modport sink(input valid, input button_levels, output ready);
endinterface

interface bgd_out_if import bgd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [IDX_W-1:0]  button_index;
	logic              click_seen;
	logic              double_click_seen;
	logic              long_push_seen;
	logic              long_release_seen;
	logic [HELD_W-1:0] held_ticks;
	logic              last_of_tick;

	modport source(output valid, output button_index, output click_seen,
		output double_click_seen, output long_push_seen, output long_release_seen,
		output held_ticks, output last_of_tick, input ready);
	modport sink(input valid, input button_index, input click_seen,
		input double_click_seen, input long_push_seen, input long_release_seen,
		input held_ticks, input last_of_tick, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/bgd_ram.sv
// ---------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module bgd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                        clk,
	input  wire logic                                        we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                            wdata,
	input  wire logic                                        re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output      logic [WIDTH-1:0]                            rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/bgd_cfg.sv
// ---------------------------------------------------------------------------
// Button gesture detector configuration registers
// Write-only register bank with reset values; unknown indexes are dropped.
// ---------------------------------------------------------------------------
`default_nettype none

module bgd_cfg import bgd_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  we,
	input  wire logic [CFG_IDX_W-1:0]  index,
	input  wire logic [CFG_DATA_W-1:0] data,
	output      cfg_t                  cfg
);
	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tick_period_ms         <= RST_TICK_PERIOD;
			cfg_q.click_ms               <= RST_CLICK_MS;
			cfg_q.release_ms             <= RST_RELEASE_MS;
			cfg_q.long_push_ms           <= RST_LONG_PUSH_MS;
			cfg_q.long_release_ms        <= RST_LONG_REL_MS;
			cfg_q.single_click_only_mask <= RST_SINGLE_MASK;
			cfg_q.active_buttons         <= RST_ACTIVE;
		end else if (we) begin
			case (cfg_idx_t'(index))
				CFG_TICK_PERIOD:  cfg_q.tick_period_ms <= data[PERIOD_W-1:0];
				CFG_CLICK_MS:     cfg_q.click_ms <= data[MS_W-1:0];
				CFG_RELEASE_MS:   cfg_q.release_ms <= data[MS_W-1:0];
				CFG_LONG_PUSH_MS: cfg_q.long_push_ms <= data[MS_W-1:0];
				CFG_LONG_REL_MS:  cfg_q.long_release_ms <= data[MS_W-1:0];
				CFG_SINGLE_MASK:  cfg_q.single_click_only_mask <= data[LEVEL_W-1:0];
				CFG_ACTIVE:       cfg_q.active_buttons <= data[ACTIVE_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// File: hw/rtl/bgd_step.sv
// ---------------------------------------------------------------------------
// Button gesture detector step logic
// One state step and counter update of a single button entry.
// ---------------------------------------------------------------------------
`default_nettype none

module bgd_step import bgd_pkg::*; #(
	parameter int CW          = 16,
	parameter int COUNT_LIMIT = 65535
) (
	input  wire logic [GST_W-1:0]       state,
	input  wire logic [CW-1:0]          press,
	input  wire logic [CW-1:0]          rel,
	input  wire logic [CW-1:0]          saved,
	input  wire logic [CW+PERIOD_W-1:0] press_prod,
	input  wire logic [CW+PERIOD_W-1:0] rel_prod,
	input  wire cfg_t                   cfg,
	input  wire logic                   pushed,
	input  wire logic                   single_only,
	output      logic [GST_W-1:0]       state_nx,
	output      logic [CW-1:0]          press_nx,
	output      logic [CW-1:0]          rel_nx,
	output      logic [CW-1:0]          saved_nx,
	output      gesture_evt_t           evt
);
	localparam int PW = CW + PERIOD_W;

	logic           hit_click;
	logic           hit_long;
	logic           hit_rel;
	logic           hit_long_rel;
	gesture_state_t nx;
	logic [CW-1:0]  p_mid;
	logic [CW-1:0]  r_mid;
	logic [CW-1:0]  s_mid;

	assign hit_click    = press_prod >= PW'(cfg.click_ms);
	assign hit_long     = press_prod >= PW'(cfg.long_push_ms);
	assign hit_rel      = rel_prod >= PW'(cfg.release_ms);
	assign hit_long_rel = rel_prod >= PW'(cfg.long_release_ms);

	always_comb begin
		nx    = gesture_state_t'(state);
		p_mid = press;
		r_mid = rel;
		s_mid = saved;
		evt   = '0;
		case (gesture_state_t'(state))
			GST_INIT: begin
				p_mid = '0;
				r_mid = '0;
				s_mid = '0;
				nx    = GST_START;
			end
			GST_START: nx = GST_CLICK_DET;
			GST_CLICK_DET: begin
				if (hit_click) begin
					s_mid = press;
					p_mid = '0;
					nx    = GST_LONG_DET;
				end else if (hit_long_rel) begin
					nx = GST_START;
				end
			end
			GST_LONG_DET: begin
				if (hit_long) begin
					nx = GST_SURE_LONG;
				end else if (hit_rel) begin
					r_mid = '0;
					nx    = single_only ? GST_SURE_CLICK : GST_CLREL_DET;
				end
			end
			GST_SURE_LONG: begin
				evt.long_push_seen = 1'b1;
				nx = GST_LPREL_DET;
			end
			GST_LPREL_DET: begin
				if (hit_rel) begin
					nx = GST_SURE_LPREL;
				end
			end
			GST_SURE_LPREL: begin
				evt.long_release_seen = 1'b1;
				evt.held_ticks = HELD_W'(saved);
				nx = GST_START;
			end
			GST_CLREL_DET: begin
				if (hit_long_rel) begin
					nx = GST_SURE_CLICK;
				end else if (hit_click) begin
					s_mid = press;
					p_mid = '0;
					nx    = GST_DBL_DET;
				end
			end
			GST_DBL_DET: begin
				if (hit_rel) begin
					nx = GST_SURE_DBL;
				end else if (hit_long) begin
					nx = GST_SURE_LONG;
				end
			end
			GST_SURE_CLICK: begin
				evt.click_seen = 1'b1;
				nx = GST_START;
			end
			GST_SURE_DBL: begin
				evt.double_click_seen = 1'b1;
				nx = GST_START;
			end
			default: nx = GST_INIT;
		endcase
	end

	// counters follow the new sample
	always_comb begin
		saved_nx = s_mid;
		if (pushed) begin
			rel_nx   = '0;
			press_nx = (p_mid < CW'(COUNT_LIMIT)) ? p_mid + 1'b1 : p_mid;
		end else begin
			if (p_mid != '0) begin
				saved_nx = p_mid;
			end
			press_nx = '0;
			rel_nx   = (r_mid < CW'(COUNT_LIMIT)) ? r_mid + 1'b1 : r_mid;
		end
	end

	assign state_nx = nx;

endmodule

`default_nettype wire

// File: hw/rtl/button_gesture_detector.sv
// ---------------------------------------------------------------------------
// Button gesture detector
// Click, double click, long push and long release recognition per button.
// ---------------------------------------------------------------------------
// Usage:
//   samples  : one request per tick, button_levels bit i high while button i
//              is pressed. Accepted while the block is idle.
//   gestures : one request per button with an event on that tick, ascending
//              button order; last_of_tick marks the final one of the tick.
//   cfg_*    : register writes, for the user to make only while no tick is
//              in progress; the block itself does not enforce this.
// Timing: the per-button state lives in one RAM. After acceptance the first
//   entry is read, then each monitored button takes a multiply step and an
//   update and write-back step while the next entry is read, a push step
//   for each event, and a final flush step; push and flush hold on a stall.
//   A tick with no monitored button is accepted without a scan.
// A result waits in a pending register until the next event of the tick or
//   the end of the scan tells whether it is the last.
// Reset: all buttons restart in the init state with zero counters, and the
//   registers take their default values; no clearing pass is needed.
// Stall: a result waits in the output register, one further in the pending
//   register and one in the event register, after which the scan holds.
// ---------------------------------------------------------------------------
`default_nettype none

module button_gesture_detector import bgd_pkg::*; #(
	parameter int BUTTONS     = 16,
	parameter int COUNT_LIMIT = 65535
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	bgd_in_if.sink                     samples,
	bgd_out_if.source                  gestures
);
	localparam int BW = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
	localparam int CW = $clog2(COUNT_LIMIT + 1);
	localparam int PW = CW + PERIOD_W;
	localparam int EW = GST_W + 3 * CW;

	cfg_t                cfg;
	seq_state_t          seq_q;
	seq_state_t          seq_d;
	logic [BW-1:0]       btn_q;
	logic [LEVEL_W-1:0]  levels_q;
	logic [BUTTONS-1:0]  vld_q;
	logic                rd_vld_q;
	logic [ACTIVE_W-1:0] n_act;
	logic                more;
	logic                push_ok;
	logic                out_free;

	logic                ram_we;
	logic                ram_re;
	logic [BW-1:0]       raddr;
	logic [EW-1:0]       rdata;
	logic [EW-1:0]       wdata;

	logic [GST_W-1:0]    e_state;
	logic [CW-1:0]       e_press;
	logic [CW-1:0]       e_rel;
	logic [CW-1:0]       e_saved;
	logic [PW-1:0]       press_prod_s1;
	logic [PW-1:0]       rel_prod_s1;

	logic [GST_W-1:0]    state_nx;
	logic [CW-1:0]       press_nx;
	logic [CW-1:0]       rel_nx;
	logic [CW-1:0]       saved_nx;
	gesture_evt_t        evt;
	logic                has_evt;

	result_t             ev_q;
	result_t             pend_q;
	logic                pend_vld_q;
	result_t             out_q;
	logic                out_vld_q;

	logic                take_in;
	logic                adv;
	logic                load_ev;
	logic                move_pend;
	logic                flush_pend;
	logic                load_pend;

	bgd_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	assign n_act = (cfg.active_buttons > ACTIVE_W'(BUTTONS)) ? ACTIVE_W'(BUTTONS)
		: cfg.active_buttons;
	assign more     = (ACTIVE_W'(btn_q) + ACTIVE_W'(1)) < n_act;
	assign out_free = !out_vld_q || gestures.ready;
	assign push_ok  = !pend_vld_q || out_free;

	// entry store
	assign ram_we = (seq_q == SEQ_EXEC);
	assign ram_re = (seq_q == SEQ_READ) || ((seq_q == SEQ_EXEC) && more);
	assign raddr  = (seq_q == SEQ_EXEC) ? btn_q + 1'b1 : btn_q;
	assign wdata  = {state_nx, press_nx, rel_nx, saved_nx};

	bgd_ram #(
		.WIDTH (EW),
		.DEPTH (BUTTONS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (btn_q),
		.wdata (wdata),
		.re    (ram_re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// an entry never written reads as the init state with zero counters
	assign {e_state, e_press, e_rel, e_saved} = rd_vld_q ? rdata : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (ram_re) begin
				rd_vld_q <= vld_q[raddr];
			end
			if (ram_we) begin
				vld_q[btn_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (seq_q == SEQ_MUL) begin
			press_prod_s1 <= PW'(e_press) * PW'(cfg.tick_period_ms);
			rel_prod_s1   <= PW'(e_rel) * PW'(cfg.tick_period_ms);
		end
	end

	bgd_step #(
		.CW          (CW),
		.COUNT_LIMIT (COUNT_LIMIT)
	) u_step (
		.state       (e_state),
		.press       (e_press),
		.rel         (e_rel),
		.saved       (e_saved),
		.press_prod  (press_prod_s1),
		.rel_prod    (rel_prod_s1),
		.cfg         (cfg),
		.pushed      (levels_q[btn_q]),
		.single_only (cfg.single_click_only_mask[btn_q]),
		.state_nx    (state_nx),
		.press_nx    (press_nx),
		.rel_nx      (rel_nx),
		.saved_nx    (saved_nx),
		.evt         (evt)
	);

	assign has_evt = evt.click_seen || evt.double_click_seen || evt.long_push_seen
		|| evt.long_release_seen;

	// sequencer next state
	always_comb begin
		seq_d = seq_q;
		case (seq_q)
			SEQ_IDLE: begin
				if (samples.valid && (n_act != '0)) begin
					seq_d = SEQ_READ;
				end
			end
			SEQ_READ: seq_d = SEQ_MUL;
			SEQ_MUL:  seq_d = SEQ_EXEC;
			SEQ_EXEC: begin
				if (has_evt) begin
					seq_d = SEQ_PUSH;
				end else begin
					seq_d = more ? SEQ_MUL : SEQ_FLUSH;
				end
			end
			SEQ_PUSH: begin
				if (push_ok) begin
					seq_d = more ? SEQ_MUL : SEQ_FLUSH;
				end
			end
			SEQ_FLUSH: begin
				if (push_ok) begin
					seq_d = SEQ_IDLE;
				end
			end
			default: seq_d = SEQ_IDLE;
		endcase
	end

	// sequencer controls
	always_comb begin
		take_in    = 1'b0;
		adv        = 1'b0;
		load_ev    = 1'b0;
		move_pend  = 1'b0;
		flush_pend = 1'b0;
		load_pend  = 1'b0;
		case (seq_q)
			SEQ_IDLE: take_in = samples.valid;
			SEQ_EXEC: begin
				load_ev = has_evt;
				adv     = !has_evt && more;
			end
			SEQ_PUSH: begin
				load_pend = push_ok;
				move_pend = push_ok && pend_vld_q;
				adv       = push_ok && more;
			end
			SEQ_FLUSH: flush_pend = pend_vld_q && out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q      <= SEQ_IDLE;
			btn_q      <= '0;
			pend_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			seq_q <= seq_d;
			if (take_in) begin
				btn_q <= '0;
			end else if (adv) begin
				btn_q <= btn_q + 1'b1;
			end
			if (load_pend) begin
				pend_vld_q <= 1'b1;
			end else if (flush_pend) begin
				pend_vld_q <= 1'b0;
			end
			if (move_pend || flush_pend) begin
				out_vld_q <= 1'b1;
			end else if (gestures.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			levels_q <= samples.button_levels;
		end
		if (load_ev) begin
			ev_q.button_index      <= IDX_W'(btn_q);
			ev_q.click_seen        <= evt.click_seen;
			ev_q.double_click_seen <= evt.double_click_seen;
			ev_q.long_push_seen    <= evt.long_push_seen;
			ev_q.long_release_seen <= evt.long_release_seen;
			ev_q.held_ticks        <= evt.held_ticks;
			ev_q.last_of_tick      <= 1'b0;
		end
		if (load_pend) begin
			pend_q <= ev_q;
		end
		if (move_pend) begin
			out_q <= pend_q;
		end else if (flush_pend) begin
			out_q              <= pend_q;
			out_q.last_of_tick <= 1'b1;
		end
	end

	assign samples.ready = (seq_q == SEQ_IDLE);

	assign gestures.valid             = out_vld_q;
	assign gestures.button_index      = out_q.button_index;
	assign gestures.click_seen        = out_q.click_seen;
	assign gestures.double_click_seen = out_q.double_click_seen;
	assign gestures.long_push_seen    = out_q.long_push_seen;
	assign gestures.long_release_seen = out_q.long_release_seen;
	assign gestures.held_ticks        = out_q.held_ticks;
	assign gestures.last_of_tick      = out_q.last_of_tick;

endmodule

`default_nettype wire

// File: hw/rtl/bgd_checker.sv
// ---------------------------------------------------------------------------
// Button gesture detector port checker
// Result channel checks, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "button_gesture_detector_defines.svh"

module bgd_checker import bgd_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire logic [IDX_W-1:0]  button_index,
	input wire logic              click_seen,
	input wire logic              double_click_seen,
	input wire logic              long_push_seen,
	input wire logic              long_release_seen,
	input wire logic [HELD_W-1:0] held_ticks,
	input wire logic              last_of_tick
);

	`BGD_ASSERT_NEXT(a_valid_hold, out_valid && !out_ready, out_valid,
		"result request dropped while stalled")

	`BGD_ASSERT_NEXT(a_payload_hold, out_valid && !out_ready,
		$stable({button_index, click_seen, double_click_seen, long_push_seen,
		long_release_seen, held_ticks, last_of_tick}), "result changed while stalled")

	`BGD_ASSERT_SAME(a_one_event, out_valid,
		$onehot({click_seen, double_click_seen, long_push_seen, long_release_seen}),
		"result must carry exactly one event")

	`BGD_ASSERT_SAME(a_held_zero, out_valid && !long_release_seen, held_ticks == '0,
		"held ticks set without long release")

endmodule

bind button_gesture_detector bgd_checker u_bgd_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.out_valid         (gestures.valid),
	.out_ready         (gestures.ready),
	.button_index      (gestures.button_index),
	.click_seen        (gestures.click_seen),
	.double_click_seen (gestures.double_click_seen),
	.long_push_seen    (gestures.long_push_seen),
	.long_release_seen (gestures.long_release_seen),
	.held_ticks        (gestures.held_ticks),
	.last_of_tick      (gestures.last_of_tick)
);

`default_nettype wire
